// ===== hw/rtl/epdm_pkg.sv =====
// ----------------------------------------------------------------------------
// epdm_pkg
// Shared types and constants for the echo pulse distance meter.
// ----------------------------------------------------------------------------
package epdm_pkg;

   // tick counter width and its saturation value
   localparam int COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // pulse width in microseconds is held in 16 bits
   localparam int US_WIDTH = 16;
   localparam logic [US_WIDTH-1:0] US_MAX = '1;

   // remainder times one hundred fits in 15 bits (254 * 100 < 2^15)
   localparam int PROD_WIDTH = 15;
   localparam logic [6:0] HUNDRED = 7'd100;

   // step counter of the shared divider
   localparam int STEP_WIDTH = $clog2(COUNT_WIDTH + 1);

   // register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICK_DIVISOR = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOUND_TIME   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DISTANCE = 2'd2;
   localparam int CSR_DATA_WIDTH = 16;

   // reset values of the registers
   localparam logic [7:0]  TICK_DIVISOR_RESET = 8'd80;
   localparam logic [7:0]  SOUND_TIME_RESET   = 8'd29;
   localparam logic [15:0] MAX_DISTANCE_RESET = 16'd450;

   typedef struct packed {
      logic [7:0]  tick_divisor;
      logic [7:0]  sound_time;
      logic [15:0] max_distance;
   } cfg_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_US,
      ST_DIV_CM,
      ST_DIV_HUND
   } back_state_type;

endpackage

// ===== hw/rtl/echo_pulse_distance_meter_core.sv =====
// ----------------------------------------------------------------------------
// echo_pulse_distance_meter_core
// Ultrasonic echo time-of-flight ranging: measures echo pulse width and
// reports distance in centimetres and hundredths.
// ----------------------------------------------------------------------------
// One echo sample is taken per cycle (req_push with req_full low); each
// falling edge that ends a measured pulse yields one result on the rsp
// queue, computed by the shared bit-serial divider that does all three
// divisions one quotient bit per cycle; the divider only starts a pulse
// once the previous result has been popped.
// Two finished pulses can wait between the sampler and the divider; while
// both are held req_full is high, until the divider takes one.
// Registers: 0 tick divisor, 1 sound time, 2 max distance.
// ----------------------------------------------------------------------------
module echo_pulse_distance_meter_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic                                    req_echo,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic [15:0]                             rsp_distance_cm,
   output logic [6:0]                              rsp_hundredths,
   output logic                                    rsp_too_far,
   input  logic                                    csr_we,
   input  logic [epdm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [epdm_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   epdm_pkg::cfg_type                cfg_ff, cfg_in;
   logic                             sample_valid;
   logic                             pulse_push;
   logic [epdm_pkg::COUNT_WIDTH-1:0] pulse_ticks;
   logic                             queue_full;
   logic                             queue_empty;
   logic                             queue_pop;
   logic [epdm_pkg::COUNT_WIDTH-1:0] queue_data;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            epdm_pkg::CSR_TICK_DIVISOR: cfg_in.tick_divisor = csr_wdata[7:0];
            epdm_pkg::CSR_SOUND_TIME:   cfg_in.sound_time   = csr_wdata[7:0];
            epdm_pkg::CSR_MAX_DISTANCE: cfg_in.max_distance = csr_wdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_divisor <= epdm_pkg::TICK_DIVISOR_RESET;
         cfg_ff.sound_time   <= epdm_pkg::SOUND_TIME_RESET;
         cfg_ff.max_distance <= epdm_pkg::MAX_DISTANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sample transfer
   assign req_full     = queue_full;
   assign sample_valid = req_push & ~queue_full;

   epdm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (sample_valid),
      .echo         (req_echo),
      .pulse_push   (pulse_push),
      .pulse_ticks  (pulse_ticks)
   );

   epdm_tick_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pulse_push),
      .push_data (pulse_ticks),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_data (queue_data),
      .empty     (queue_empty)
   );

   epdm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .queue_empty     (queue_empty),
      .queue_data      (queue_data),
      .queue_pop       (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_distance_cm (rsp_distance_cm),
      .rsp_hundredths  (rsp_hundredths),
      .rsp_too_far     (rsp_too_far)
   );

endmodule

// ===== hw/rtl/epdm_front.sv =====
// ----------------------------------------------------------------------------
// epdm_front
// Echo edge detection and saturating pulse width counter. Emits the tick
// count of each finished pulse.
// ----------------------------------------------------------------------------
module epdm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                sample_valid,
   input  logic                                echo,
   output logic                                pulse_push,
   output logic [epdm_pkg::COUNT_WIDTH-1:0]    pulse_ticks
);

   logic                             last_echo_ff, last_echo_in;
   logic                             measuring_ff, measuring_in;
   logic [epdm_pkg::COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [epdm_pkg::COUNT_WIDTH-1:0] tick_sat;
   logic                             rising;
   logic                             falling;

   // edge classification and counting
   always_comb begin
      rising       = echo & ~last_echo_ff;
      falling      = ~echo & last_echo_ff;
      tick_sat     = (tick_ff < epdm_pkg::COUNT_MAX) ? tick_ff + 1'b1 : tick_ff;
      last_echo_in = last_echo_ff;
      measuring_in = measuring_ff;
      tick_in      = tick_ff;
      pulse_push   = 1'b0;
      if (sample_valid) begin
         last_echo_in = echo;
         if (rising) begin
            tick_in      = '0;
            measuring_in = 1'b1;
         end else if (measuring_ff) begin
            tick_in = tick_sat;
            if (falling) begin
               pulse_push   = 1'b1;
               measuring_in = 1'b0;
            end
         end
      end
   end

   assign pulse_ticks = tick_sat;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_echo_ff <= 1'b0;
         measuring_ff <= 1'b0;
         tick_ff      <= '0;
      end else begin
         last_echo_ff <= last_echo_in;
         measuring_ff <= measuring_in;
         tick_ff      <= tick_in;
      end
   end

endmodule

// ===== hw/rtl/epdm_tick_queue.sv =====
// ----------------------------------------------------------------------------
// epdm_tick_queue
// Two-entry queue of pulse tick counts between front and back end.
// ----------------------------------------------------------------------------
module epdm_tick_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [epdm_pkg::COUNT_WIDTH-1:0] push_data,
   output logic                             full,
   input  logic                             pop,
   output logic [epdm_pkg::COUNT_WIDTH-1:0] head_data,
   output logic                             empty
);

   logic [epdm_pkg::COUNT_WIDTH-1:0] entry_ff [2];
   logic                             wr_ptr_ff, wr_ptr_in;
   logic                             rd_ptr_ff, rd_ptr_in;
   logic [1:0]                       count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   // occupancy and pointers
   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      do_push   = push & ~full;
      do_pop    = pop & ~empty;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      head_data = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/epdm_back.sv =====
// ----------------------------------------------------------------------------
// epdm_back
// Converts a pulse tick count to centimetres and hundredths with one shared
// bit-serial divider, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module epdm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  epdm_pkg::cfg_type                cfg,
   input  logic                             queue_empty,
   input  logic [epdm_pkg::COUNT_WIDTH-1:0] queue_data,
   output logic                             queue_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [15:0]                      rsp_distance_cm,
   output logic [6:0]                       rsp_hundredths,
   output logic                             rsp_too_far
);

   localparam int CW = epdm_pkg::COUNT_WIDTH;

   epdm_pkg::back_state_type state_ff, state_in;
   logic [epdm_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic [CW-1:0]                   quo_ff, quo_in;
   logic [7:0]                      rem_ff, rem_in;
   logic [7:0]                      dsr_ff, dsr_in;
   logic [15:0]                     cm_ff, cm_in;
   logic                            valid_ff, valid_in;
   logic [15:0]                     out_cm_ff;
   logic [6:0]                      out_hund_ff;
   logic                            out_far_ff;
   logic                            out_load;

   logic [7:0]                      div_eff;
   logic [7:0]                      st_eff;
   logic [8:0]                      trial;
   logic                            fits;
   logic [CW-1:0]                   quo_step;
   logic [7:0]                      rem_step;
   logic [epdm_pkg::US_WIDTH-1:0]   us_sat;
   logic [epdm_pkg::PROD_WIDTH-1:0] prod;
   logic                            steps_done;

   // zero divisors read as one
   assign div_eff = (cfg.tick_divisor == 8'd0) ? 8'd1 : cfg.tick_divisor;
   assign st_eff  = (cfg.sound_time == 8'd0) ? 8'd1 : cfg.sound_time;

   // one restoring division step
   always_comb begin
      trial    = {rem_ff, quo_ff[CW-1]};
      fits     = (trial >= {1'b0, dsr_ff});
      rem_step = fits ? 8'(trial - {1'b0, dsr_ff}) : trial[7:0];
      quo_step = {quo_ff[CW-2:0], fits};
   end

   // saturate microseconds, scale remainder
   assign us_sat = (quo_ff > CW'(epdm_pkg::US_MAX)) ? epdm_pkg::US_MAX
                                                    : quo_ff[epdm_pkg::US_WIDTH-1:0];
   assign prod       = epdm_pkg::PROD_WIDTH'(rem_ff) *
                       epdm_pkg::PROD_WIDTH'(epdm_pkg::HUNDRED);
   assign steps_done = (step_ff == '0);

   // sequencer: next state and outputs
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      cm_in     = cm_ff;
      valid_in  = valid_ff & ~rsp_pop;
      queue_pop = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         epdm_pkg::ST_IDLE: begin
            if (!queue_empty && !valid_ff) begin
               queue_pop = 1'b1;
               quo_in    = queue_data;
               rem_in    = '0;
               dsr_in    = div_eff;
               step_in   = epdm_pkg::STEP_WIDTH'(CW);
               state_in  = epdm_pkg::ST_DIV_US;
            end
         end
         epdm_pkg::ST_DIV_US: begin
            if (steps_done) begin
               quo_in   = CW'(us_sat) << (CW - epdm_pkg::US_WIDTH);
               rem_in   = '0;
               dsr_in   = st_eff;
               step_in  = epdm_pkg::STEP_WIDTH'(epdm_pkg::US_WIDTH);
               state_in = epdm_pkg::ST_DIV_CM;
            end else begin
               quo_in  = quo_step;
               rem_in  = rem_step;
               step_in = step_ff - 1'b1;
            end
         end
         epdm_pkg::ST_DIV_CM: begin
            if (steps_done) begin
               cm_in    = quo_ff[15:0];
               quo_in   = CW'(prod) << (CW - epdm_pkg::PROD_WIDTH);
               rem_in   = '0;
               step_in  = epdm_pkg::STEP_WIDTH'(epdm_pkg::PROD_WIDTH);
               state_in = epdm_pkg::ST_DIV_HUND;
            end else begin
               quo_in  = quo_step;
               rem_in  = rem_step;
               step_in = step_ff - 1'b1;
            end
         end
         epdm_pkg::ST_DIV_HUND: begin
            if (steps_done) begin
               out_load = 1'b1;
               valid_in = 1'b1;
               state_in = epdm_pkg::ST_IDLE;
            end else begin
               quo_in  = quo_step;
               rem_in  = rem_step;
               step_in = step_ff - 1'b1;
            end
         end
         default: begin
            state_in = epdm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epdm_pkg::ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cm_ff  <= cm_in;
      if (out_load) begin
         out_cm_ff   <= cm_ff;
         out_hund_ff <= quo_ff[6:0];
         out_far_ff  <= (cm_ff > cfg.max_distance);
      end
   end

   assign rsp_empty       = ~valid_ff;
   assign rsp_distance_cm = out_cm_ff;
   assign rsp_hundredths  = out_hund_ff;
   assign rsp_too_far     = out_far_ff;

endmodule
